// ===== design/alt_pkg.sv =====
// ---------------------------------------------------------------------------
// alt_pkg: shared types and codes for the allocation leak tracker
// Event modes, result kinds, table entry record and cell control/status.
// ---------------------------------------------------------------------------
package alt_pkg;

  // field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned OFF_W   = 31;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned COUNT_W = 32;

  // event modes
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_RECORDED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DUP_ALLOC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREED     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUP_FREE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LEAK      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NO_LEAKS  = 3'd6;

  // one table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  offset;
  } entry_t;

  // broadcast control into every cell
  typedef struct packed {
    logic alloc_en;
    logic free_en;
    logic dump_en;
  } cell_ctl_t;

  // per-cell status back to the table
  typedef struct packed {
    logic hit;
    logic sel;
  } cell_stat_t;

  // summary of the whole table for the controller
  typedef struct packed {
    logic any_hit;
    logic any_free;
    logic any_live;
    logic more_live;
  } table_stat_t;

endpackage

// ===== design/alt_cell.sv =====
// ---------------------------------------------------------------------------
// alt_cell: one slot of the live allocation table
// Holds one entry, matches the broadcast address and passes the lowest-free
// and lowest-live tokens on to the next cell.
// ---------------------------------------------------------------------------
module alt_cell
  import alt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              any_hit,
  input  logic [ADDR_W-1:0] key_addr,
  input  entry_t            wr_entry,
  input  logic              free_in,
  input  logic              live_in,
  input  logic              second_in,
  output logic              free_out,
  output logic              live_out,
  output logic              second_out,
  output cell_stat_t        stat,
  output entry_t            sel_entry
);

  logic   valid_r;
  logic   valid_nxt;
  entry_t entry_r;
  logic   hit;
  logic   take_free;
  logic   take_live;
  logic   write_en;

  // local match and token chains
  assign hit        = valid_r && (entry_r.addr == key_addr);
  assign take_free  = !valid_r && !free_in;
  assign take_live  = valid_r && !live_in;
  assign free_out   = free_in || !valid_r;
  assign live_out   = live_in || valid_r;
  assign second_out = second_in || (live_in && valid_r);

  assign write_en = ctl.alloc_en && !any_hit && take_free;

  // status and masked entry for the or-reduction
  assign stat.hit  = hit;
  assign stat.sel  = ctl.dump_en ? take_live : hit;
  assign sel_entry = stat.sel ? entry_r : '0;

  // slot valid update
  always_comb begin
    valid_nxt = valid_r;
    if (write_en) begin
      valid_nxt = 1'b1;
    end else if (ctl.free_en && hit) begin
      valid_nxt = 1'b0;
    end else if (ctl.dump_en && take_live) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (write_en) begin
      entry_r <= wr_entry;
    end
  end

endmodule

// ===== design/alt_table.sv =====
// ---------------------------------------------------------------------------
// alt_table: row of table cells
// Links the cells into a chain and reduces their status and selected entry.
// ---------------------------------------------------------------------------
module alt_table
  import alt_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [ADDR_W-1:0] key_addr,
  input  entry_t            wr_entry,
  output table_stat_t       tstat,
  output entry_t            sel_entry
);

  logic       free_chain   [ENTRIES+1];
  logic       live_chain   [ENTRIES+1];
  logic       second_chain [ENTRIES+1];
  cell_stat_t stat         [ENTRIES];
  entry_t     cell_entry   [ENTRIES];
  logic       any_hit;

  assign free_chain[0]   = 1'b0;
  assign live_chain[0]   = 1'b0;
  assign second_chain[0] = 1'b0;

  // chain of cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    alt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .any_hit    (any_hit),
      .key_addr   (key_addr),
      .wr_entry   (wr_entry),
      .free_in    (free_chain[g]),
      .live_in    (live_chain[g]),
      .second_in  (second_chain[g]),
      .free_out   (free_chain[g+1]),
      .live_out   (live_chain[g+1]),
      .second_out (second_chain[g+1]),
      .stat       (stat[g]),
      .sel_entry  (cell_entry[g])
    );
  end

  // or-reduce hits and the one-hot selected entry
  always_comb begin
    any_hit   = 1'b0;
    sel_entry = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      any_hit   = any_hit | stat[i].hit;
      sel_entry = sel_entry | cell_entry[i];
    end
  end

  assign tstat.any_hit   = any_hit;
  assign tstat.any_free  = free_chain[ENTRIES];
  assign tstat.any_live  = live_chain[ENTRIES];
  assign tstat.more_live = second_chain[ENTRIES];

endmodule

// ===== design/allocation_leak_tracker_top.sv =====
// ---------------------------------------------------------------------------
// allocation_leak_tracker_top: live heap allocation tracker
// Follows a malloc/free trace and reports duplicates, frees and leaks.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one trace event per item, carrying
//   mode (free, alloc, dump), address, size and trace offset.
//   Result channel (out_valid/out_stall): one result item per free or alloc
//   event; a dump gives one leak item per live entry in slot order, the
//   final one flagged by out_last, or a single no-leaks item.
//   Every result carries the running byte total and alloc count.
// Sequence:
//   A free or alloc event is accepted in IDLE; in EXEC all cells compare the
//   address in parallel and the table updates once the output register is
//   free. A dump is accepted in IDLE, then one live entry per cycle leaves
//   the cell row in DUMP while the output register is free. Events with an
//   unused mode drop in the accept cycle. One event is in flight at a time.
// Reset: synchronous, active low; empties the table and clears totals.
// Stall: a result is held in the output register while out_stall is high;
//   the block stops in its current step until the register frees up.
// ---------------------------------------------------------------------------
module allocation_leak_tracker_top
  import alt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 32
)
(
  input  logic               clk,
  input  logic               rst_n,
  // event input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [ADDR_W-1:0]  in_addr,
  input  logic [SIZE_W-1:0]  in_size,
  input  logic [OFF_W-1:0]   in_trace_offset,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_kind,
  output logic [ADDR_W-1:0]  out_entry_addr_out,
  output logic [SIZE_W-1:0]  out_entry_size_out,
  output logic [OFF_W-1:0]   out_entry_offset_out,
  output logic               out_last,
  output logic [TOTAL_W-1:0] out_total_bytes,
  output logic [COUNT_W-1:0] out_alloc_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]         state_r;
  logic [1:0]         state_nxt;
  logic [MODE_W-1:0]  mode_r;
  entry_t             ev_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [TOTAL_W:0]   total_sum;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [KIND_W-1:0]  kind_r;
  logic [KIND_W-1:0]  kind_nxt;
  entry_t             res_r;
  entry_t             res_nxt;
  logic               last_r;
  logic               last_nxt;
  logic               out_load;

  logic               out_free;
  logic               accept;
  cell_ctl_t          ctl;
  table_stat_t        tstat;
  entry_t             sel_entry;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // broadcast control to the cell row
  assign ctl.alloc_en = (state_r == ST_EXEC) && (mode_r == MODE_ALLOC) && out_free;
  assign ctl.free_en  = (state_r == ST_EXEC) && (mode_r == MODE_FREE) && out_free;
  assign ctl.dump_en  = (state_r == ST_DUMP) && out_free;

  alt_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .key_addr  (ev_r.addr),
    .wr_entry  (ev_r),
    .tstat     (tstat),
    .sel_entry (sel_entry)
  );

  // saturating running totals
  assign total_sum = {1'b0, total_r} + {{(TOTAL_W + 1 - SIZE_W){1'b0}}, ev_r.size};

  always_comb begin
    total_nxt = total_r;
    count_nxt = count_r;
    if (ctl.alloc_en) begin
      total_nxt = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
      if (count_r != {COUNT_W{1'b1}}) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // sequencer and result selection
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    kind_nxt  = kind_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_FREE || in_mode == MODE_ALLOC) begin
            state_nxt = ST_EXEC;
          end else if (in_mode == MODE_DUMP) begin
            state_nxt = ST_DUMP;
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
          res_nxt   = ev_r;
          if (mode_r == MODE_ALLOC) begin
            if (tstat.any_hit) begin
              kind_nxt = KIND_DUP_ALLOC;
            end else if (tstat.any_free) begin
              kind_nxt = KIND_RECORDED;
            end else begin
              kind_nxt = KIND_FULL;
            end
          end else if (tstat.any_hit) begin
            kind_nxt       = KIND_FREED;
            res_nxt.size   = sel_entry.size;
            res_nxt.offset = sel_entry.offset;
          end else begin
            kind_nxt     = KIND_DUP_FREE;
            res_nxt.size = '0;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (tstat.any_live) begin
            kind_nxt = KIND_LEAK;
            res_nxt  = sel_entry;
            last_nxt = !tstat.more_live;
          end else begin
            kind_nxt = KIND_NO_LEAKS;
            res_nxt  = '0;
            last_nxt = 1'b1;
          end
          if (!tstat.more_live) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
    end
  end

  // event capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r      <= in_mode;
      ev_r.addr   <= in_addr;
      ev_r.size   <= in_size;
      ev_r.offset <= in_trace_offset;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r <= kind_nxt;
      res_r  <= res_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = kind_r;
  assign out_entry_addr_out   = res_r.addr;
  assign out_entry_size_out   = res_r.size;
  assign out_entry_offset_out = res_r.offset;
  assign out_last             = last_r;
  assign out_total_bytes      = total_r;
  assign out_alloc_count      = count_r;

endmodule
